// ===== hdl/rcn_pkg.sv =====
`default_nettype none
package rcn_pkg;
	localparam int PixW = 32;
	localparam int NumCfg = 8;
	localparam int MaxLineW = 1024;
	localparam logic [2:0] CFG_COEF_TOP = 3'd0;
	localparam logic [2:0] CFG_COEF_MID = 3'd1;
	localparam logic [2:0] CFG_COEF_BOT = 3'd2;
	localparam logic [2:0] CFG_CHAN_EN = 3'd3;
	localparam logic [2:0] CFG_GAIN = 3'd4;
	localparam logic [2:0] CFG_BIAS = 3'd5;
	localparam logic [2:0] CFG_WIDTH = 3'd6;
	localparam logic [2:0] CFG_HEIGHT = 3'd7;

	typedef enum logic [1:0] {F_IDLE, F_READ, F_EMIT} fstate_t;
	typedef enum logic [1:0] {B_IDLE, B_MAC, B_GAIN, B_OUT} bstate_t;

	// window item handed from front to back
	typedef struct packed {
		logic [8:0][PixW-1:0] win;
		logic [9:0] col;
		logic [15:0] row;
		logic last;
	} win_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [9:0] col;
		logic [15:0] row;
		logic last;
	} res_item_t;
endpackage
`default_nettype wire

// ===== hdl/rcn_ram.sv =====
`default_nettype none
module rcn_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/rcn_front.sv =====
`default_nettype none
module rcn_front import rcn_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic sof,
	input wire logic [PixW-1:0] px,
	input wire logic [10:0] image_width,
	input wire logic [15:0] image_height,
	output logic q_valid,
	input wire logic q_ready,
	output win_item_t q_item
);
	localparam int AW = $clog2(MaxLineW);
	fstate_t state_q, state_d;
	logic [9:0] col_q;
	logic [15:0] row_q;
	logic [9:0] col_c;
	logic [15:0] row_c;
	logic [10:0] w_eff;
	logic [15:0] h_eff;
	logic [PixW-1:0] px_q;
	logic [9:0] pcol_q;
	logic [15:0] prow_q;
	logic [8:0][PixW-1:0] win_q;
	logic [PixW-1:0] a2, a1;
	logic [AW-1:0] addr_q;
	logic take;

	always_comb begin
		w_eff = image_width;
		if (image_width < 11'd3) w_eff = 11'd3;
		if ({21'd0, image_width} > MaxLineW) w_eff = 11'(MaxLineW);
		h_eff = (image_height < 16'd3) ? 16'd3 : image_height;
		col_c = col_q;
		row_c = row_q;
		if (sof) begin
			col_c = '0;
			row_c = '0;
		end
		if ({1'b0, col_c} >= w_eff) begin
			col_c = '0;
			row_c = row_c + 16'd1;
		end
		if (row_c >= h_eff) row_c = '0;
	end

	assign in_ready = (state_q == F_IDLE);
	assign take = in_valid && in_ready;

	rcn_ram #(.Width(PixW), .Depth(MaxLineW)) u_l0 (
		.clk(clk), .we(state_q == F_READ), .waddr(addr_q), .wdata(a1),
		.re(take), .raddr(AW'(col_c)), .rdata(a2));
	rcn_ram #(.Width(PixW), .Depth(MaxLineW)) u_l1 (
		.clk(clk), .we(state_q == F_READ), .waddr(addr_q), .wdata(px_q),
		.re(take), .raddr(AW'(col_c)), .rdata(a1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (take) state_d = F_READ;
			F_READ: state_d = (pcol_q >= 10'd2 && prow_q >= 16'd2) ? F_EMIT : F_IDLE;
			F_EMIT: if (q_ready) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	assign q_valid = (state_q == F_EMIT);
	always_comb begin
		q_item.win = win_q;
		q_item.col = pcol_q - 10'd1;
		q_item.row = prow_q - 16'd1;
		q_item.last = ({1'b0, pcol_q} == w_eff - 11'd1) && (prow_q == h_eff - 16'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			col_q <= '0;
			row_q <= '0;
			win_q <= '0;
		end else begin
			state_q <= state_d;
			if (take) begin
				if ({1'b0, col_c} + 11'd1 >= w_eff) begin
					col_q <= '0;
					row_q <= (row_c + 16'd1 >= h_eff) ? 16'd0 : row_c + 16'd1;
				end else begin
					col_q <= col_c + 10'd1;
					row_q <= row_c;
				end
			end
			if (state_q == F_READ) begin
				// window rows: index r*3+k
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= a2;
				win_q[3] <= win_q[4];
				win_q[4] <= win_q[5];
				win_q[5] <= a1;
				win_q[6] <= win_q[7];
				win_q[7] <= win_q[8];
				win_q[8] <= px_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			px_q <= px;
			pcol_q <= col_c;
			prow_q <= row_c;
			addr_q <= AW'(col_c);
		end
	end
endmodule
`default_nettype wire

// ===== hdl/rcn_back.sv =====
`default_nettype none
module rcn_back import rcn_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_ready,
	input wire win_item_t q_item,
	input wire logic [47:0] coef_top,
	input wire logic [47:0] coef_mid,
	input wire logic [47:0] coef_bot,
	input wire logic [3:0] chan_en,
	input wire logic [23:0] gain,
	input wire logic [8:0] bias,
	output logic r_valid,
	input wire logic r_ready,
	output res_item_t r_item
);
	// one multiply-accumulate per cycle: 9 taps x 4 channels, then gain multiply
	bstate_t state_q, state_d;
	win_item_t it_q;
	logic [3:0] tap_q;
	logic [1:0] ch_q;
	logic signed [27:0] acc_q;
	logic [3:0][7:0] res_q;
	logic [143:0] coefs;
	logic signed [15:0] cf;
	logic [7:0] pv;
	logic signed [27:0] acc_n;
	logic signed [53:0] t_n;
	logic [7:0] clampv;
	logic [7:0] ctr;

	assign coefs = {coef_bot, coef_mid, coef_top};
	assign cf = coefs[tap_q*16 +: 16];
	assign pv = it_q.win[tap_q][ch_q*8 +: 8];
	assign acc_n = acc_q + 28'(cf) * 28'($signed({1'b0, pv}));
	// gain applied to the finished sum, rounded once
	assign t_n = 54'(acc_q) * 54'($signed({1'b0, gain}))
		+ 54'($signed({1'b0, bias, 24'd0})) + 54'sd8388608;
	assign ctr = it_q.win[4][ch_q*8 +: 8];
	always_comb begin
		if (t_n < 0) clampv = 8'd0;
		else if (t_n[53:24] > 30'd255) clampv = 8'd255;
		else clampv = t_n[31:24];
	end

	assign q_ready = (state_q == B_IDLE);
	assign r_valid = (state_q == B_OUT);
	always_comb begin
		r_item.red = res_q[0];
		r_item.green = res_q[1];
		r_item.blue = res_q[2];
		r_item.alpha = res_q[3];
		r_item.col = it_q.col;
		r_item.row = it_q.row;
		r_item.last = it_q.last;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (q_valid) state_d = B_MAC;
			B_MAC: if (tap_q == 4'd8) state_d = B_GAIN;
			B_GAIN: if (ch_q == 2'd3) state_d = B_OUT;
				else state_d = B_MAC;
			B_OUT: if (r_ready) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			tap_q <= '0;
			ch_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				B_IDLE: begin
					tap_q <= '0;
					ch_q <= '0;
				end
				B_MAC: if (tap_q != 4'd8) tap_q <= tap_q + 4'd1;
				B_GAIN: begin
					tap_q <= '0;
					ch_q <= ch_q + 2'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && q_valid) it_q <= q_item;
		if (state_q == B_IDLE || state_q == B_GAIN) acc_q <= '0;
		else if (state_q == B_MAC) acc_q <= acc_n;
		if (state_q == B_GAIN) res_q[ch_q] <= chan_en[ch_q] ? clampv : ctr;
	end
endmodule
`default_nettype wire

// ===== hdl/rgba_conv3x3_normalized.sv =====
// the front takes no new word until it is done with the last one,
// and the back takes no new window until its result word is taken
// the back end runs one multiply-accumulate per cycle over 9 taps and 4 channels
// a two-entry queue between window front and filter back lets each side stall alone
// arst_n clears control, counters, window and registers to defaults; line stores are not cleared
`default_nettype none
module rgba_conv3x3_normalized import rcn_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [31:0] s_axis_tdata, // in_red, in_green, in_blue, in_alpha
	input wire logic s_axis_tuser, // start_of_frame
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [63:0] m_axis_tdata, // out_red, out_green, out_blue, out_alpha, out_col, out_row
	output logic m_axis_tlast, // last_of_frame
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [47:0] cfg_data
);
	logic [47:0] coef_top_q, coef_mid_q, coef_bot_q;
	logic [3:0] chan_en_q;
	logic [23:0] gain_q;
	logic [8:0] bias_q;
	logic [10:0] width_q;
	logic [15:0] height_q;
	logic fv, fr, bv, br;
	win_item_t fi, bi;
	win_item_t fifo_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	res_item_t ri;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_top_q <= '0;
			coef_mid_q <= 48'd16777216;
			coef_bot_q <= '0;
			chan_en_q <= 4'd7;
			gain_q <= 24'd65536;
			bias_q <= '0;
			width_q <= 11'd1024;
			height_q <= 16'd1024;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_COEF_TOP: coef_top_q <= cfg_data;
				CFG_COEF_MID: coef_mid_q <= cfg_data;
				CFG_COEF_BOT: coef_bot_q <= cfg_data;
				CFG_CHAN_EN: chan_en_q <= cfg_data[3:0];
				CFG_GAIN: gain_q <= cfg_data[23:0];
				CFG_BIAS: bias_q <= cfg_data[8:0];
				CFG_WIDTH: width_q <= cfg_data[10:0];
				CFG_HEIGHT: height_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	rcn_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.sof(s_axis_tuser), .px(s_axis_tdata), .image_width(width_q),
		.image_height(height_q), .q_valid(fv), .q_ready(fr), .q_item(fi));

	// two-entry queue
	assign fr = (cnt_q != 2'd2);
	assign bv = (cnt_q != 2'd0);
	assign bi = fifo_q[rp_q];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (fv && fr) wp_q <= ~wp_q;
			if (bv && br) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(fv && fr) - 2'(bv && br);
		end
	end
	always_ff @(posedge clk) begin
		if (fv && fr) fifo_q[wp_q] <= fi;
	end

	rcn_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(bv), .q_ready(br), .q_item(bi),
		.coef_top(coef_top_q), .coef_mid(coef_mid_q), .coef_bot(coef_bot_q),
		.chan_en(chan_en_q), .gain(gain_q), .bias(bias_q),
		.r_valid(m_axis_tvalid), .r_ready(m_axis_tready), .r_item(ri));

	assign m_axis_tdata = {6'd0, ri.row, ri.col, ri.alpha, ri.blue, ri.green, ri.red};
	assign m_axis_tlast = ri.last;
endmodule
`default_nettype wire

// ===== hdl/rcn_checker.sv =====
`default_nettype none
module rcn_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [63:0] m_axis_tdata,
	input wire logic m_axis_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");
	a_col: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[41:32] != 10'd0)
		else $error("result column on edge");
	a_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[57:42] != 16'd0)
		else $error("result row on edge");
	a_nodouble: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("front took two words back to back");
endmodule
bind rgba_conv3x3_normalized rcn_checker u_rcn_checker (.*);
`default_nettype wire
